@@ hdl/tmc_pkg.sv @@
// Shared types and constants for the transform matrix composer.
// Holds the command codes, the controller/datapath command and status words,
// and the fixed Q5.30 constants of the angle reduction and the CORDIC unit.
package tmc_pkg;

	localparam int VAL_W        = 32;
	localparam int DEN_W        = 15;
	localparam int ANG_W        = 35;
	localparam int CORDIC_STEPS = 30;
	localparam int MAT_N        = 16;

	localparam logic signed [ANG_W-1:0] Q30_ONE_PI  = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_GAIN    = 35'sd652032874;

	typedef enum logic [2:0] {
		ACT_IDENT = 3'd0,
		ACT_PROJ  = 3'd1,
		ACT_TRANS = 3'd2,
		ACT_ROTX  = 3'd3,
		ACT_ROTY  = 3'd4,
		ACT_ROTZ  = 3'd5,
		ACT_SCALE = 3'd6,
		ACT_READ  = 3'd7
	} act_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD_ID,
		DP_DIV_LOAD,
		DP_DIV_STEP,
		DP_DIV_STORE,
		DP_PROJ_FIN,
		DP_ANG_LOAD,
		DP_ANG_MOD,
		DP_ANG_WRAP,
		DP_ANG_FOLD,
		DP_CORDIC,
		DP_SC_FIN,
		DP_MAC,
		DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [5:0] cnt;
		logic [1:0] sel;
		logic       capture;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_stat_t;

	// arctangent of 2^-i in Q5.30; past the table it equals 2^-i
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:    v = 35'sd843314857;
			5'd1:    v = 35'sd497837829;
			5'd2:    v = 35'sd263043837;
			5'd3:    v = 35'sd133525159;
			5'd4:    v = 35'sd67021687;
			5'd5:    v = 35'sd33543516;
			5'd6:    v = 35'sd16775851;
			5'd7:    v = 35'sd8388437;
			5'd8:    v = 35'sd4194283;
			5'd9:    v = 35'sd2097149;
			default: v = 35'sd1 <<< (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage

@@ hdl/tmc_cmd_if.sv @@
// Command channel of the transform matrix composer.
// Depends on nothing; valid/ready handshake with the command payload.
interface tmc_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] op_x;
	logic signed [31:0] op_y;
	logic signed [31:0] op_z;
	logic signed [31:0] rotation_angle;
	logic [14:0]        view_width;
	logic [14:0]        view_height;
	logic [14:0]        view_depth;

	modport source (
		output valid, action, op_x, op_y, op_z, rotation_angle,
		       view_width, view_height, view_depth,
		input  ready
	);
	modport sink (
		input  valid, action, op_x, op_y, op_z, rotation_angle,
		       view_width, view_height, view_depth,
		output ready
	);
endinterface

@@ hdl/tmc_entry_if.sv @@
// Read-out channel of the transform matrix composer: one matrix entry per word.
// Depends on nothing; valid/ready handshake with the entry payload.
interface tmc_entry_if;
	logic               valid;
	logic               ready;
	logic [3:0]         entry_index;
	logic signed [31:0] entry_value;
	logic               last_entry;

	modport source (
		output valid, entry_index, entry_value, last_entry,
		input  ready
	);
	modport sink (
		input  valid, entry_index, entry_value, last_entry,
		output ready
	);
endinterface

@@ hdl/transform_matrix_composer_core.sv @@
// Transform matrix composer: keeps a running 4x4 Q16.16 transform matrix and
// applies one command word at a time. Depends on tmc_pkg, tmc_cmd_if,
// tmc_entry_if, tmc_ctrl and tmc_dp.
//
// One command word is taken only while the block is idle; cmd.ready drops until
// the command is finished. Identity reloads the unit matrix. Projection runs three
// restoring divisions on a shared divider, one quotient bit per cycle, to Q16.16
// results. Translate and scale run through a single 32x32 multiplier (one
// product per cycle, one column of four new entries at a time) and then drain
// the multiply pipe. Rotations first reduce the angle (Q16.16 radians) modulo
// 2*pi one compare-subtract per cycle, then run 30 CORDIC iterations, then the
// same composition. A read command emits 16 entry words in row-major order
// through an output register, one per cycle when the sink is ready, with
// last_entry set on the sixteenth; all other commands produce no words.
// Composed entries are rounded half up and saturate to signed 32 bits.
module transform_matrix_composer_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tmc_cmd_if.sink     cmd,
	tmc_entry_if.source entry
);

	tmc_pkg::ctrl_cmd_t dp_cmd;
	tmc_pkg::dp_stat_t  dp_stat;

	// sequence commands and pace the read-out
	tmc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_action (tmc_pkg::act_t'(cmd.action)),
		.in_ready  (cmd.ready),
		.out_ready (entry.ready),
		.out_valid (entry.valid),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// matrix store and arithmetic
	tmc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.cmd_action  (cmd.action),
		.cmd_op_x    (cmd.op_x),
		.cmd_op_y    (cmd.op_y),
		.cmd_op_z    (cmd.op_z),
		.cmd_angle   (cmd.rotation_angle),
		.cmd_width   (cmd.view_width),
		.cmd_height  (cmd.view_height),
		.cmd_depth   (cmd.view_depth),
		.entry_index (entry.entry_index),
		.entry_value (entry.entry_value),
		.last_entry  (entry.last_entry)
	);

	// an accepted command drops cmd.ready in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted back to back");

	// no entry word waits while the block is idle
	a_idle_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !entry.valid)
		else $error("entry word pending while idle");

	// the multiply pipe only runs while a command is in progress
	a_pipe_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.busy |-> !cmd.ready)
		else $error("datapath busy while idle");

	// the last flag marks exactly the final row-major entry
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		entry.valid |-> (entry.last_entry == (entry.entry_index == 4'd15)))
		else $error("last_entry out of place");

endmodule

@@ hdl/tmc_dp.sv @@
// Datapath of the transform matrix composer: matrix registers, shared
// multiply-accumulate pipe, restoring divider, angle reduction and CORDIC.
// Depends on tmc_pkg; driven step by step by tmc_ctrl.
module tmc_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmc_pkg::ctrl_cmd_t    cmd,
	output tmc_pkg::dp_stat_t     stat,
	input  logic [2:0]            cmd_action,
	input  logic signed [31:0]    cmd_op_x,
	input  logic signed [31:0]    cmd_op_y,
	input  logic signed [31:0]    cmd_op_z,
	input  logic signed [31:0]    cmd_angle,
	input  logic [14:0]           cmd_width,
	input  logic [14:0]           cmd_height,
	input  logic [14:0]           cmd_depth,
	output logic [3:0]            entry_index,
	output logic signed [31:0]    entry_value,
	output logic                  last_entry
);

	localparam int NB = FRAC_BITS + 3;
	localparam int RW = 62 - FRAC_BITS;
	localparam int SH = 30 - FRAC_BITS;
	localparam int JM = 28 - FRAC_BITS;
	localparam int AW = tmc_pkg::ANG_W;

	localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] HALF_ONE = 32'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] RND66    = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] SAT_MAX  = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN  = -66'sd2147483648;
	localparam logic signed [AW-1:0] SC_RND = 35'sd1 <<< (29 - FRAC_BITS);

	// captured command
	tmc_pkg::act_t      action_q;
	logic signed [31:0] ox_q, oy_q, oz_q, ang_q;
	logic [14:0]        w_q, h_q, d_q;

	logic signed [31:0] cur_q [tmc_pkg::MAT_N];
	logic signed [31:0] colbuf_q [3];

	// divider
	logic [NB-1:0] dvd_q, quo_q;
	logic [15:0]   rem_q;
	logic [14:0]   den_q;

	// angle / cordic
	logic [RW-1:0]          mag_q;
	logic                   neg_q, flip_q;
	logic signed [AW-1:0]   x_q, y_q, z_q;
	logic signed [31:0]     sin_q, cos_q;

	// multiply-accumulate pipe
	logic signed [63:0] prod_s1;
	logic               v_s1, first_s1, last_s1;
	logic [1:0]         r_s1, c_s1;
	logic signed [65:0] acc_q, fin_s2;
	logic               v_s2;
	logic [1:0]         r_s2, c_s2;

	logic [3:0]         idx_q;
	logic signed [31:0] val_q;
	logic               last_q;

	// combinational helpers
	logic [1:0]           mk, mr, mc;
	logic signed [31:0]   op_sel;
	logic signed [63:0]   prod_c;
	logic signed [65:0]   sum_c, rnd_c;
	logic signed [31:0]   sat_val;
	logic [15:0]          div_tr;
	logic [NB:0]          div_rnd;
	logic signed [31:0]   div_res;
	logic signed [RW-1:0] r_full;
	logic [RW-1:0]        mod_cand;
	logic signed [AW-1:0] m_s, wrap_z, cdx, cdy, cos_x;
	logic [5:0]           mod_sh;
	logic [4:0]           ci;

	assign mk = cmd.cnt[1:0];
	assign mr = cmd.cnt[3:2];
	assign mc = cmd.cnt[5:4];

	// elementary operator entry for row mr, column mk
	always_comb begin
		op_sel = (mr == mk) ? ONE : '0;
		case (action_q)
			tmc_pkg::ACT_TRANS: begin
				case ({mr, mk})
					4'b11_00: op_sel = ox_q;
					4'b11_01: op_sel = oy_q;
					4'b11_10: op_sel = oz_q;
					default:  ;
				endcase
			end
			tmc_pkg::ACT_SCALE: begin
				case ({mr, mk})
					4'b00_00: op_sel = ox_q;
					4'b01_01: op_sel = oy_q;
					4'b10_10: op_sel = oz_q;
					default:  ;
				endcase
			end
			tmc_pkg::ACT_ROTX: begin
				case ({mr, mk})
					4'b01_01, 4'b10_10: op_sel = cos_q;
					4'b01_10:           op_sel = sin_q;
					4'b10_01:           op_sel = -sin_q;
					default:            ;
				endcase
			end
			tmc_pkg::ACT_ROTY: begin
				case ({mr, mk})
					4'b00_00, 4'b10_10: op_sel = cos_q;
					4'b00_10:           op_sel = -sin_q;
					4'b10_00:           op_sel = sin_q;
					default:            ;
				endcase
			end
			tmc_pkg::ACT_ROTZ: begin
				case ({mr, mk})
					4'b00_00, 4'b01_01: op_sel = cos_q;
					4'b00_01:           op_sel = sin_q;
					4'b01_00:           op_sel = -sin_q;
					default:            ;
				endcase
			end
			default: ;
		endcase
	end

	assign prod_c = op_sel * cur_q[{mk, mc}];
	assign sum_c  = (first_s1 ? 66'sd0 : acc_q) + 66'(prod_s1);
	assign rnd_c  = (fin_s2 + RND66) >>> FRAC_BITS;

	always_comb begin
		if (rnd_c > SAT_MAX)
			sat_val = 32'sh7fffffff;
		else if (rnd_c < SAT_MIN)
			sat_val = 32'sh80000000;
		else
			sat_val = rnd_c[31:0];
	end

	assign div_tr  = {rem_q[14:0], dvd_q[NB-1]};
	assign div_rnd = ((NB+1)'(quo_q) + (NB+1)'(1)) >> 1;
	assign div_res = 32'(div_rnd);

	assign r_full   = RW'(ang_q) <<< SH;
	assign mod_sh   = 6'(JM) - cmd.cnt;
	assign mod_cand = RW'(tmc_pkg::Q30_TWO_PI) << mod_sh;

	// fold the remainder into [-pi, pi]
	always_comb begin
		m_s = AW'(mag_q);
		if (m_s > tmc_pkg::Q30_ONE_PI)
			wrap_z = neg_q ? tmc_pkg::Q30_TWO_PI - m_s : m_s - tmc_pkg::Q30_TWO_PI;
		else
			wrap_z = neg_q ? -m_s : m_s;
	end

	assign ci    = cmd.cnt[4:0];
	assign cdx   = y_q >>> ci;
	assign cdy   = x_q >>> ci;
	assign cos_x = flip_q ? -x_q : x_q;

	assign stat.busy = v_s1 | v_s2;

	// matrix store and pipe control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tmc_pkg::MAT_N; i++)
				cur_q[i] <= (i % 5 == 0) ? ONE : '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (cmd.op == tmc_pkg::DP_MAC);
			v_s2 <= v_s1 && last_s1;
			if (v_s2 && r_s2 == 2'd3) begin
				for (int rr = 0; rr < 3; rr++)
					cur_q[{2'(rr), c_s2}] <= colbuf_q[rr];
				cur_q[{2'd3, c_s2}] <= sat_val;
			end
			unique case (cmd.op)
				tmc_pkg::DP_LOAD_ID: begin
					for (int i = 0; i < tmc_pkg::MAT_N; i++)
						cur_q[i] <= (i % 5 == 0) ? ONE : '0;
				end
				tmc_pkg::DP_DIV_STORE: begin
					unique case (cmd.sel)
						2'd0:    cur_q[0]  <= div_res;
						2'd1:    cur_q[5]  <= -div_res;
						default: cur_q[10] <= div_res;
					endcase
				end
				tmc_pkg::DP_PROJ_FIN: begin
					for (int i = 0; i < tmc_pkg::MAT_N; i++)
						if (i != 0 && i != 5 && i != 10)
							cur_q[i] <= '0;
					cur_q[12] <= -ONE;
					cur_q[13] <= ONE;
					cur_q[14] <= HALF_ONE;
					cur_q[15] <= ONE;
				end
				default: ;
			endcase
		end
	end

	// payload, multiply pipe, divider, angle, CORDIC and output registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= tmc_pkg::act_t'(cmd_action);
			ox_q     <= cmd_op_x;
			oy_q     <= cmd_op_y;
			oz_q     <= cmd_op_z;
			ang_q    <= cmd_angle;
			w_q      <= cmd_width;
			h_q      <= cmd_height;
			d_q      <= cmd_depth;
		end

		prod_s1  <= prod_c;
		first_s1 <= (mk == 2'd0);
		last_s1  <= (mk == 2'd3);
		r_s1     <= mr;
		c_s1     <= mc;
		if (v_s1) begin
			acc_q <= sum_c;
			if (last_s1) begin
				fin_s2 <= sum_c;
				r_s2   <= r_s1;
				c_s2   <= c_s1;
			end
		end
		if (v_s2 && r_s2 != 2'd3)
			colbuf_q[r_s2] <= sat_val;

		unique case (cmd.op)
			tmc_pkg::DP_DIV_LOAD: begin
				dvd_q <= (cmd.sel == 2'd2) ? NB'(1) << FRAC_BITS : NB'(1) << (FRAC_BITS + 2);
				rem_q <= '0;
				quo_q <= '0;
				unique case (cmd.sel)
					2'd0:    den_q <= (w_q == '0) ? 15'd1 : w_q;
					2'd1:    den_q <= (h_q == '0) ? 15'd1 : h_q;
					default: den_q <= (d_q == '0) ? 15'd1 : d_q;
				endcase
			end
			tmc_pkg::DP_DIV_STEP: begin
				dvd_q <= dvd_q << 1;
				if (div_tr >= {1'b0, den_q}) begin
					rem_q <= div_tr - {1'b0, den_q};
					quo_q <= {quo_q[NB-2:0], 1'b1};
				end else begin
					rem_q <= div_tr;
					quo_q <= {quo_q[NB-2:0], 1'b0};
				end
			end
			tmc_pkg::DP_ANG_LOAD: begin
				neg_q <= ang_q[31];
				mag_q <= ang_q[31] ? RW'(-r_full) : RW'(r_full);
			end
			tmc_pkg::DP_ANG_MOD: begin
				if (mag_q >= mod_cand)
					mag_q <= mag_q - mod_cand;
			end
			tmc_pkg::DP_ANG_WRAP: z_q <= wrap_z;
			tmc_pkg::DP_ANG_FOLD: begin
				x_q <= tmc_pkg::Q30_GAIN;
				y_q <= '0;
				if (z_q > tmc_pkg::Q30_HALF_PI) begin
					z_q    <= tmc_pkg::Q30_ONE_PI - z_q;
					flip_q <= 1'b1;
				end else if (z_q < -tmc_pkg::Q30_HALF_PI) begin
					z_q    <= -tmc_pkg::Q30_ONE_PI - z_q;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
			end
			tmc_pkg::DP_CORDIC: begin
				if (!z_q[AW-1]) begin
					x_q <= x_q - cdx;
					y_q <= y_q + cdy;
					z_q <= z_q - tmc_pkg::atan_step(ci);
				end else begin
					x_q <= x_q + cdx;
					y_q <= y_q - cdy;
					z_q <= z_q + tmc_pkg::atan_step(ci);
				end
			end
			tmc_pkg::DP_SC_FIN: begin
				sin_q <= 32'((y_q + SC_RND) >>> SH);
				cos_q <= 32'((cos_x + SC_RND) >>> SH);
			end
			tmc_pkg::DP_OUT_LOAD: begin
				idx_q  <= cmd.cnt[3:0];
				val_q  <= cur_q[cmd.cnt[3:0]];
				last_q <= (cmd.cnt[3:0] == 4'd15);
			end
			default: ;
		endcase
	end

	assign entry_index = idx_q;
	assign entry_value = val_q;
	assign last_entry  = last_q;

endmodule

@@ hdl/tmc_ctrl.sv @@
// Controller of the transform matrix composer: sequences each command
// through the datapath and paces the read-out words. Depends on tmc_pkg.
module tmc_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tmc_pkg::act_t      in_action,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  tmc_pkg::dp_stat_t  stat,
	output tmc_pkg::ctrl_cmd_t cmd
);

	localparam int NB = FRAC_BITS + 3;
	localparam int JM = 28 - FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_IDENT, S_DIV_LOAD, S_DIV_STEP, S_DIV_STORE, S_PROJ_FIN,
		S_ANG_LOAD, S_ANG_MOD, S_ANG_WRAP, S_ANG_FOLD, S_CORDIC, S_SC_FIN,
		S_MAC, S_DRAIN, S_READ
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic [1:0] sel_q;
	logic       out_valid_q;
	logic       in_fire, rd_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign rd_fire   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op      = tmc_pkg::DP_NOP;
		cmd.cnt     = cnt_q;
		cmd.sel     = sel_q;
		cmd.capture = in_fire;
		unique case (state_q)
			S_IDENT:     cmd.op = tmc_pkg::DP_LOAD_ID;
			S_DIV_LOAD:  cmd.op = tmc_pkg::DP_DIV_LOAD;
			S_DIV_STEP:  cmd.op = tmc_pkg::DP_DIV_STEP;
			S_DIV_STORE: cmd.op = tmc_pkg::DP_DIV_STORE;
			S_PROJ_FIN:  cmd.op = tmc_pkg::DP_PROJ_FIN;
			S_ANG_LOAD:  cmd.op = tmc_pkg::DP_ANG_LOAD;
			S_ANG_MOD:   cmd.op = tmc_pkg::DP_ANG_MOD;
			S_ANG_WRAP:  cmd.op = tmc_pkg::DP_ANG_WRAP;
			S_ANG_FOLD:  cmd.op = tmc_pkg::DP_ANG_FOLD;
			S_CORDIC:    cmd.op = tmc_pkg::DP_CORDIC;
			S_SC_FIN:    cmd.op = tmc_pkg::DP_SC_FIN;
			S_MAC:       cmd.op = tmc_pkg::DP_MAC;
			S_READ:      cmd.op = (rd_fire && !cnt_q[4]) ? tmc_pkg::DP_OUT_LOAD
			                                             : tmc_pkg::DP_NOP;
			default:     cmd.op = tmc_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					sel_q <= '0;
					if (in_fire) begin
						unique case (in_action) inside
							tmc_pkg::ACT_IDENT:                   state_q <= S_IDENT;
							tmc_pkg::ACT_PROJ:                    state_q <= S_DIV_LOAD;
							tmc_pkg::ACT_TRANS, tmc_pkg::ACT_SCALE: state_q <= S_MAC;
							tmc_pkg::ACT_ROTX, tmc_pkg::ACT_ROTY,
							tmc_pkg::ACT_ROTZ:                    state_q <= S_ANG_LOAD;
							default:                              state_q <= S_READ;
						endcase
					end
				end
				S_IDENT: state_q <= S_IDLE;
				S_DIV_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					if (cnt_q == 6'(NB - 1))
						state_q <= S_DIV_STORE;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				S_DIV_STORE: begin
					if (sel_q == 2'd2) begin
						state_q <= S_PROJ_FIN;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= S_DIV_LOAD;
					end
				end
				S_PROJ_FIN: state_q <= S_IDLE;
				S_ANG_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_ANG_MOD;
				end
				S_ANG_MOD: begin
					if (cnt_q == 6'(JM))
						state_q <= S_ANG_WRAP;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				S_ANG_WRAP: state_q <= S_ANG_FOLD;
				S_ANG_FOLD: begin
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					if (cnt_q == 6'(tmc_pkg::CORDIC_STEPS - 1))
						state_q <= S_SC_FIN;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				S_SC_FIN: begin
					cnt_q   <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (cnt_q == 6'd63)
						state_q <= S_DRAIN;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				S_DRAIN: begin
					if (!stat.busy)
						state_q <= S_IDLE;
				end
				S_READ: begin
					if (rd_fire) begin
						if (cnt_q[4]) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							out_valid_q <= 1'b1;
							cnt_q       <= cnt_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
